>>> design/histogram_split_gain_engine_unit_defines.svh
// assertion macros for the split gain engine checker
`ifndef HISTOGRAM_SPLIT_GAIN_ENGINE_UNIT_DEFINES_SVH
`define HISTOGRAM_SPLIT_GAIN_ENGINE_UNIT_DEFINES_SVH

// same-cycle implication
`define HSGE_ASSERT_IMPL(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("hsge check failed");

// next-cycle implication
`define HSGE_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("hsge check failed");

`endif

>>> design/hsge_pkg.sv
// shared types and constants for the split gain engine
package hsge_pkg;

    localparam int FEATURES_DEF    = 16;
    localparam int BINS_DEF        = 256;
    localparam int MAX_SAMPLES_DEF = 1048576;

    localparam int ACT_W  = 3;
    localparam int FEAT_W = 4;
    localparam int BIN_W  = 8;
    localparam int TGT_W  = 32;
    localparam int SUM_W  = 52;
    localparam int CNT_W  = 21;
    localparam int MASK_W = 16;
    localparam int GAIN_W = 48;
    localparam int IN_W   = 144;
    localparam int MAG_W  = SUM_W + 1;
    localparam int SQ_W   = 2 * SUM_W + 1;
    localparam int NUM_W  = SQ_W + 1;
    localparam int DEN_W  = CNT_W + 16;
    localparam int STEP_W = 7;

    localparam logic [ACT_W-1:0] ACT_CLEAR = 3'd0;
    localparam logic [ACT_W-1:0] ACT_ACCUM = 3'd1;
    localparam logic [ACT_W-1:0] ACT_FINAL = 3'd2;
    localparam logic [ACT_W-1:0] ACT_SUB   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_QUERY = 3'd4;

    localparam logic CFG_MIN_LEAF  = 1'b0;
    localparam logic CFG_USED_MASK = 1'b1;

    localparam logic [1:0] PH_LEFT  = 2'd0;
    localparam logic [1:0] PH_RIGHT = 2'd1;
    localparam logic [1:0] PH_NODE  = 2'd2;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_RMW,
        S_FIN,
        S_QRD0,
        S_QRD1,
        S_EVAL,
        S_SIDE,
        S_MUL,
        S_DIV,
        S_PUSH
    } t_state;

endpackage

>>> design/histogram_split_gain_engine_unit.sv
// split gain engine top level: histogram store, prefix sweep, gain datapath
// accumulate/subtract read then write the cell; finalize and clear sweep every cell
//   a valid query reads two cells, squares and divides per side, then divides by the node count
// throughput: one item at a time; a new item is taken once the result register is loaded
// the gain path is a shift-add squarer and a restoring divider, one bit per cycle
// reset: synchronous active low, then a clearing pass over every ram cell
module histogram_split_gain_engine_unit
    import hsge_pkg::*;
#(
    parameter int FEATURES    = FEATURES_DEF,
    parameter int BINS        = BINS_DEF,
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_index,
    input  logic [CNT_W-1:0]  i_cfg_data,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // feature, bin, target, entry_sum, entry_count, sample_total, zero pad
    input  logic [IN_W-1:0]   s_axis_tdata,
    // action
    input  logic [ACT_W-1:0]  s_axis_tuser,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // gain
    output logic [GAIN_W-1:0] m_axis_tdata,
    // gain_valid, done_res
    output logic [1:0]        m_axis_tuser
);

    localparam int CELLS = FEATURES * BINS;
    localparam int AW    = $clog2(CELLS);
    localparam int BIW   = $clog2(BINS);
    localparam int MW    = SUM_W + CNT_W;

    function automatic logic [SUM_W-1:0] f_sat(input logic [SUM_W:0] v);
        if (v[SUM_W] != v[SUM_W-1]) begin
            return v[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end
        return v[SUM_W-1:0];
    endfunction

    logic [FEAT_W-1:0] w_feat;
    logic [BIN_W-1:0]  w_bin;
    logic [TGT_W-1:0]  w_tgt;
    logic [SUM_W-1:0]  w_esum;
    logic [CNT_W-1:0]  w_ecnt;
    logic [CNT_W-1:0]  w_stot;
    logic              w_inr;
    logic [AW-1:0]     w_idx;

    assign w_feat = s_axis_tdata[3:0];
    assign w_bin  = s_axis_tdata[11:4];
    assign w_tgt  = s_axis_tdata[43:12];
    assign w_esum = s_axis_tdata[95:44];
    assign w_ecnt = s_axis_tdata[116:96];
    assign w_stot = s_axis_tdata[137:117];
    assign w_inr  = (int'(w_feat) < FEATURES) && (int'(w_bin) < BINS);
    assign w_idx  = AW'(int'(w_feat) * BINS + int'(w_bin));

    t_state             r_state, n_state;
    logic [AW-1:0]      r_addr, n_addr;
    logic [BIW-1:0]     r_fbin, n_fbin;
    logic [SUM_W-1:0]   r_psum, n_psum;
    logic [CNT_W-1:0]   r_pcnt, n_pcnt;
    logic               r_push, n_push;
    logic [ACT_W-1:0]   r_act, n_act;
    logic               r_do_wr, n_do_wr;
    logic [TGT_W-1:0]   r_tgt, n_tgt;
    logic [SUM_W-1:0]   r_esum, n_esum;
    logic [CNT_W-1:0]   r_ecnt, n_ecnt;
    logic [AW-1:0]      r_last, n_last;
    logic [SUM_W-1:0]   r_sl, n_sl, r_slast, n_slast;
    logic [CNT_W-1:0]   r_nl, n_nl, r_clast, n_clast, r_nr, n_nr;
    logic [MAG_W-1:0]   r_sr, n_sr;
    logic [1:0]         r_phase, n_phase;
    logic [STEP_W-1:0]  r_cnt, n_cnt;
    logic [SQ_W-1:0]    r_mca, n_mca, r_prod, n_prod;
    logic [MAG_W-1:0]   r_mpl, n_mpl;
    logic [NUM_W-1:0]   r_num, n_num, r_tsum, n_tsum;
    logic [DEN_W-1:0]   r_rem, n_rem, r_den, n_den;
    logic [GAIN_W-1:0]  r_res_gain, n_res_gain;
    logic               r_res_valid, n_res_valid, r_res_done, n_res_done;
    logic [CNT_W-1:0]   r_node, n_node;
    logic [CNT_W-1:0]   r_min_leaf;
    logic [MASK_W-1:0]  r_used_mask;
    logic               r_m_tvalid, n_m_tvalid;
    logic [GAIN_W-1:0]  r_m_tdata, n_m_tdata;
    logic [1:0]         r_m_tuser, n_m_tuser;

    logic               w_we;
    logic [AW-1:0]      w_waddr, w_raddr;
    logic [MW-1:0]      w_wdata, w_rdata;
    logic [SUM_W-1:0]   w_rsum;
    logic [CNT_W-1:0]   w_rcnt;

    hsge_ram #(.W(MW), .D(CELLS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_rsum = w_rdata[SUM_W-1:0];
    assign w_rcnt = w_rdata[MW-1:SUM_W];

    // gain datapath pieces
    logic [CNT_W-1:0]  w_side_n;
    logic [MAG_W-1:0]  w_side_s, w_mag;
    logic [SQ_W-1:0]   w_prodn;
    logic [DEN_W:0]    w_rsh;
    logic              w_qb;
    logic [NUM_W-1:0]  w_qnext, w_tsum_n;
    logic [SUM_W:0]    w_s53;
    logic [CNT_W:0]    w_c22;
    logic [CNT_W-1:0]  w_nr_c;
    logic              w_valid_c;

    assign w_side_n = (r_phase == PH_LEFT) ? r_nl : r_nr;
    assign w_side_s = (r_phase == PH_LEFT) ? {r_sl[SUM_W-1], r_sl} : r_sr;
    assign w_mag    = w_side_s[MAG_W-1] ? (~w_side_s + MAG_W'(1)) : w_side_s;
    assign w_prodn  = r_mpl[0] ? (r_prod + r_mca) : r_prod;
    assign w_rsh    = {r_rem, r_num[NUM_W-1]};
    assign w_qb     = (w_rsh >= {1'b0, r_den});
    assign w_qnext  = {r_num[NUM_W-2:0], w_qb};
    assign w_tsum_n = r_tsum + w_qnext;
    assign w_nr_c   = (r_clast > r_nl) ? (r_clast - r_nl) : '0;
    assign w_valid_c = (r_nl >= r_min_leaf) && (w_nr_c >= r_min_leaf);

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_m_tvalid;
    assign m_axis_tdata  = r_m_tdata;
    assign m_axis_tuser  = r_m_tuser;

    always_comb begin
        n_state = r_state;   n_addr = r_addr;     n_fbin = r_fbin;
        n_psum = r_psum;     n_pcnt = r_pcnt;     n_push = r_push;
        n_act = r_act;       n_do_wr = r_do_wr;   n_tgt = r_tgt;
        n_esum = r_esum;     n_ecnt = r_ecnt;     n_last = r_last;
        n_sl = r_sl;         n_slast = r_slast;   n_nl = r_nl;
        n_clast = r_clast;   n_nr = r_nr;         n_sr = r_sr;
        n_phase = r_phase;   n_cnt = r_cnt;       n_mca = r_mca;
        n_prod = r_prod;     n_mpl = r_mpl;       n_num = r_num;
        n_tsum = r_tsum;     n_rem = r_rem;       n_den = r_den;
        n_res_gain = r_res_gain; n_res_valid = r_res_valid; n_res_done = r_res_done;
        n_node = r_node;
        n_m_tvalid = r_m_tvalid; n_m_tdata = r_m_tdata; n_m_tuser = r_m_tuser;
        w_we = 1'b0;
        w_waddr = r_addr;
        w_wdata = '0;
        w_raddr = r_addr;
        w_s53 = '0;
        w_c22 = '0;

        if (r_m_tvalid && m_axis_tready) begin
            n_m_tvalid = 1'b0;
        end

        case (r_state)
            S_CLR: begin
                w_we = 1'b1;
                n_addr = r_addr + AW'(1);
                if (r_addr == AW'(CELLS - 1)) begin
                    n_state = r_push ? S_PUSH : S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_act = s_axis_tuser;
                    n_tgt = w_tgt;
                    n_esum = w_esum;
                    n_ecnt = w_ecnt;
                    n_res_gain = '0;
                    n_res_valid = 1'b0;
                    n_res_done = 1'b1;
                    case (s_axis_tuser)
                        ACT_CLEAR: begin
                            n_addr = '0;
                            n_push = 1'b1;
                            n_node = '0;
                            n_state = S_CLR;
                        end
                        ACT_ACCUM, ACT_SUB: begin
                            w_raddr = w_idx;
                            n_addr = w_idx;
                            n_do_wr = (s_axis_tuser == ACT_ACCUM)
                                ? (w_inr && !r_used_mask[w_feat]) : w_inr;
                            if (s_axis_tuser == ACT_SUB && w_inr && w_feat == '0
                                && w_bin == '0) begin
                                n_node = (r_node > w_stot) ? (r_node - w_stot) : '0;
                            end
                            n_state = S_RMW;
                        end
                        ACT_FINAL: begin
                            w_raddr = '0;
                            n_addr = '0;
                            n_fbin = '0;
                            n_node = (int'(w_stot) > MAX_SAMPLES)
                                ? CNT_W'(MAX_SAMPLES) : w_stot;
                            n_state = S_FIN;
                        end
                        ACT_QUERY: begin
                            w_raddr = w_idx;
                            n_last = AW'(int'(w_feat) * BINS + BINS - 1);
                            n_state = w_inr ? S_QRD0 : S_PUSH;
                        end
                        default: begin
                            n_res_done = 1'b0;
                            n_state = S_PUSH;
                        end
                    endcase
                end
            end
            S_RMW: begin
                if (r_act == ACT_ACCUM) begin
                    w_s53 = {w_rsum[SUM_W-1], w_rsum}
                        + {{(SUM_W-TGT_W+1){r_tgt[TGT_W-1]}}, r_tgt};
                    w_wdata = {((w_rcnt == '1) ? w_rcnt : (w_rcnt + CNT_W'(1))),
                               f_sat(w_s53)};
                end else begin
                    w_s53 = {w_rsum[SUM_W-1], w_rsum} - {r_esum[SUM_W-1], r_esum};
                    w_wdata = {((w_rcnt > r_ecnt) ? (w_rcnt - r_ecnt) : CNT_W'(0)),
                               f_sat(w_s53)};
                end
                w_we = r_do_wr;
                n_state = S_PUSH;
            end
            S_FIN: begin
                w_s53 = {w_rsum[SUM_W-1], w_rsum}
                    + ((r_fbin == '0) ? '0 : {r_psum[SUM_W-1], r_psum});
                w_c22 = {1'b0, w_rcnt} + ((r_fbin == '0) ? '0 : {1'b0, r_pcnt});
                w_wdata = {(w_c22[CNT_W] ? {CNT_W{1'b1}} : w_c22[CNT_W-1:0]),
                           f_sat(w_s53)};
                w_we = 1'b1;
                w_raddr = r_addr + AW'(1);
                n_psum = w_wdata[SUM_W-1:0];
                n_pcnt = w_wdata[MW-1:SUM_W];
                n_addr = r_addr + AW'(1);
                n_fbin = (r_fbin == BIW'(BINS - 1)) ? '0 : (r_fbin + BIW'(1));
                if (r_addr == AW'(CELLS - 1)) begin
                    n_state = S_PUSH;
                end
            end
            S_QRD0: begin
                n_sl = w_rsum;
                n_nl = w_rcnt;
                w_raddr = r_last;
                n_state = S_QRD1;
            end
            S_QRD1: begin
                n_slast = w_rsum;
                n_clast = w_rcnt;
                n_state = S_EVAL;
            end
            S_EVAL: begin
                n_nr = w_nr_c;
                n_sr = {r_slast[SUM_W-1], r_slast} - {r_sl[SUM_W-1], r_sl};
                n_res_valid = w_valid_c;
                n_tsum = '0;
                n_phase = PH_LEFT;
                n_state = (w_valid_c && r_node != '0) ? S_SIDE : S_PUSH;
            end
            S_SIDE: begin
                n_cnt = '0;
                n_rem = '0;
                if (w_side_n == '0) begin
                    if (r_phase == PH_LEFT) begin
                        n_phase = PH_RIGHT;
                    end else begin
                        n_num = r_tsum;
                        n_den = {r_node, 16'h0000};
                        n_phase = PH_NODE;
                        n_state = S_DIV;
                    end
                end else begin
                    n_mca = SQ_W'(w_mag);
                    n_mpl = w_mag;
                    n_prod = '0;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_prod = w_prodn;
                n_mca = r_mca << 1;
                n_mpl = r_mpl >> 1;
                n_cnt = r_cnt + STEP_W'(1);
                if (r_cnt == STEP_W'(MAG_W - 1)) begin
                    n_num = {1'b0, w_prodn};
                    n_den = DEN_W'(w_side_n);
                    n_rem = '0;
                    n_cnt = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_rem = w_qb ? DEN_W'(w_rsh - {1'b0, r_den}) : w_rsh[DEN_W-1:0];
                n_num = w_qnext;
                n_cnt = r_cnt + STEP_W'(1);
                if (r_cnt == STEP_W'(NUM_W - 1)) begin
                    n_cnt = '0;
                    n_rem = '0;
                    if (r_phase == PH_LEFT) begin
                        n_tsum = w_tsum_n;
                        n_phase = PH_RIGHT;
                        n_state = S_SIDE;
                    end else if (r_phase == PH_RIGHT) begin
                        n_num = w_tsum_n;
                        n_den = {r_node, 16'h0000};
                        n_phase = PH_NODE;
                    end else begin
                        n_res_gain = (w_qnext[NUM_W-1:GAIN_W] != '0)
                            ? {GAIN_W{1'b1}} : w_qnext[GAIN_W-1:0];
                        n_state = S_PUSH;
                    end
                end
            end
            S_PUSH: begin
                if (!r_m_tvalid || m_axis_tready) begin
                    n_m_tvalid = 1'b1;
                    n_m_tdata = r_res_gain;
                    n_m_tuser = {r_res_done, r_res_valid};
                    n_push = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_addr <= '0;
            r_push <= 1'b0;
            r_node <= '0;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_addr <= n_addr;
            r_push <= n_push;
            r_node <= n_node;
            r_m_tvalid <= n_m_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_leaf <= CNT_W'(1);
            r_used_mask <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MIN_LEAF:  r_min_leaf <= i_cfg_data;
                CFG_USED_MASK: r_used_mask <= i_cfg_data[MASK_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_fbin <= n_fbin;       r_psum <= n_psum;       r_pcnt <= n_pcnt;
        r_act <= n_act;         r_do_wr <= n_do_wr;     r_tgt <= n_tgt;
        r_esum <= n_esum;       r_ecnt <= n_ecnt;       r_last <= n_last;
        r_sl <= n_sl;           r_slast <= n_slast;     r_nl <= n_nl;
        r_clast <= n_clast;     r_nr <= n_nr;           r_sr <= n_sr;
        r_phase <= n_phase;     r_cnt <= n_cnt;         r_mca <= n_mca;
        r_prod <= n_prod;       r_mpl <= n_mpl;         r_num <= n_num;
        r_tsum <= n_tsum;       r_rem <= n_rem;         r_den <= n_den;
        r_res_gain <= n_res_gain;
        r_res_valid <= n_res_valid;
        r_res_done <= n_res_done;
        r_m_tdata <= n_m_tdata;
        r_m_tuser <= n_m_tuser;
    end

endmodule

>>> design/hsge_ram.sv
// generic simple dual port ram with registered read
module hsge_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

>>> design/hsge_checker.sv
// port-level checks for the split gain engine, bound to the top level
`include "histogram_split_gain_engine_unit_defines.svh"

module hsge_checker
    import hsge_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              s_axis_tvalid,
    input logic              s_axis_tready,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [GAIN_W-1:0] m_axis_tdata,
    input logic [1:0]        m_axis_tuser
);

    `HSGE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    `HSGE_ASSERT_IMPL(a_valid_done, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[0], m_axis_tuser[1])
    `HSGE_ASSERT_IMPL(a_gain_valid, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tdata != '0), m_axis_tuser == 2'b11)
    `HSGE_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

endmodule

bind histogram_split_gain_engine_unit hsge_checker u_hsge_checker (.*);
